// ===== rtl/gpio_kp_pkg.sv =====
// shared types, register map constants and the pin update function of the gpio block
package gpio_kp_pkg;

    typedef logic [15:0] t_word;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PIN   = 2'd2,
        CMD_KEY   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_word pin;
        t_word edges;
    } t_port_upd;

    localparam logic [2:0] ACC_BYTE = 3'd1;
    localparam logic [2:0] ACC_WORD = 3'd4;

    localparam logic [9:0] GRP_STATE = 10'h000;
    localparam logic [9:0] GRP_DIR   = 10'h020;
    localparam logic [9:0] GRP_SET   = 10'h040;
    localparam logic [9:0] GRP_CLR   = 10'h060;
    localparam logic [9:0] GRP_FALL  = 10'h080;
    localparam logic [9:0] GRP_RISE  = 10'h0a0;
    localparam logic [9:0] GRP_EDGE  = 10'h0c0;
    localparam logic [9:0] GRP_MASK  = 10'h120;

    localparam logic [9:0] ADDR_ID    = 10'h100;
    localparam logic [9:0] ADDR_RST   = 10'h210;
    localparam logic [7:0] RST_BYTE   = 8'hff;
    localparam t_word      ID_WORD    = 16'h4741;

    localparam logic [9:0] ADDR_RSV0 = 10'h140;
    localparam logic [9:0] ADDR_RSV1 = 10'h164;
    localparam logic [9:0] ADDR_RSV2 = 10'h180;
    localparam logic [9:0] ADDR_RSV3 = 10'h184;
    localparam logic [9:0] ADDR_RSV4 = 10'h188;
    localparam logic [9:0] ADDR_RSV5 = 10'h18c;
    localparam logic [9:0] ADDR_RSV6 = 10'h194;
    localparam logic [9:0] ADDR_RSV7 = 10'h200;
    localparam logic [9:0] ADDR_RSV8 = 10'h204;

    localparam int KEY_PORT     = 2;
    localparam int KEY_COL_BASE = 8;

    // new pin state and edge latch of one port
    function automatic t_port_upd port_update(
        input t_word before_v,
        input t_word out_v,
        input t_word dir_v,
        input t_word ext_v,
        input t_word fall_v,
        input t_word rise_v,
        input t_word edge_v
    );
        t_port_upd res;
        t_word     after_v;
        t_word     chg;
        after_v   = (out_v & dir_v) | (ext_v & ~dir_v);
        chg       = before_v ^ after_v;
        res.pin   = after_v;
        res.edges = edge_v | (chg & before_v & fall_v) | (chg & after_v & rise_v);
        return res;
    endfunction

endpackage

// ===== rtl/gpio_keypad_edge_irq_ctrl.sv =====
// gpio controller top level: register window, edge detect, key matrix and irq line
// throughput: one beat per cycle while the result side does not stall; the register
//   path runs from the input register through decode, key matrix column resolve and
//   port update into the state and result registers
// reset: i_rst_n synchronous active low clears all port registers and key state,
//   sets the irq line enable, and empties both pipeline registers
module gpio_keypad_edge_irq_ctrl #(
    parameter int NUM_PORTS   = 4,
    parameter int KEYPAD_SIZE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [9:0]  i_addr,
    input  logic [2:0]  i_access_bytes,
    input  logic [31:0] i_wdata,
    input  logic [1:0]  i_port_sel,
    input  logic [3:0]  i_pin,
    input  logic        i_level,
    input  logic [2:0]  i_key_row,
    input  logic [2:0]  i_key_col,
    input  logic        i_pressed,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_rdata,
    output logic        o_ok,
    output logic        o_irq_n
);

    typedef gpio_kp_pkg::t_word t_word;

    // input register
    logic                    r_in_valid;
    gpio_kp_pkg::t_cmd       r_cmd;
    logic [9:0]              r_addr;
    logic [2:0]              r_size;
    logic [31:0]             r_wdata;
    logic [1:0]              r_port;
    logic [3:0]              r_pin;
    logic                    r_level;
    logic [2:0]              r_row;
    logic [2:0]              r_col;
    logic                    r_pressed;

    // result register
    logic                    r_out_valid;
    logic [15:0]             r_rdata;
    logic                    r_ok;
    logic                    r_irq_n;

    // irq line enable
    logic                    r_irq_en;

    // port state
    t_word r_out  [NUM_PORTS];
    t_word r_ext  [NUM_PORTS];
    t_word r_dir  [NUM_PORTS];
    t_word r_rise [NUM_PORTS];
    t_word r_fall [NUM_PORTS];
    t_word r_edge [NUM_PORTS];
    t_word r_mask [NUM_PORTS];
    t_word r_pst  [NUM_PORTS];
    logic [KEYPAD_SIZE-1:0] r_key [KEYPAD_SIZE];

    // state after the access itself, before matrix and pin update
    t_word a_out  [NUM_PORTS];
    t_word a_ext  [NUM_PORTS];
    t_word a_dir  [NUM_PORTS];
    t_word a_rise [NUM_PORTS];
    t_word a_fall [NUM_PORTS];
    t_word a_edge [NUM_PORTS];
    t_word a_mask [NUM_PORTS];
    logic [KEYPAD_SIZE-1:0] n_key [KEYPAD_SIZE];

    // final next state
    t_word n_ext  [NUM_PORTS];
    t_word n_edge [NUM_PORTS];
    t_word n_pst  [NUM_PORTS];

    logic                   advance;
    logic                   matrix_run;
    logic [KEYPAD_SIZE-1:0] w_col_hi;
    logic [15:0]            n_rdata;
    logic                   n_ok;
    logic                   n_irq_n;

    // the item in the input register moves on unless the result register is held
    assign advance     = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;

    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_rdata;
    assign o_ok        = r_ok;
    assign o_irq_n     = r_irq_n;

    // access decode and register writes
    always_comb begin
        logic       is_bus;
        logic       wr;
        logic       word;
        logic       port_grp;
        logic       port_ok;
        logic       reg_hit;
        logic [9:0] grp;
        logic [1:0] prt;
        logic       soft_rst;
        logic       pin_ok;
        logic       key_ok;
        logic       key_chg;
        logic       do_dir;
        logic       do_set;
        logic       do_clr;
        logic       do_fall;
        logic       do_rise;
        logic       do_edge;
        logic       do_mask;
        logic       rd_state;
        logic       rd_id;
        t_word      val;
        t_word      rd;

        is_bus   = (r_cmd == gpio_kp_pkg::CMD_READ) || (r_cmd == gpio_kp_pkg::CMD_WRITE);
        wr       = (r_cmd == gpio_kp_pkg::CMD_WRITE);
        word     = is_bus && (r_size == gpio_kp_pkg::ACC_WORD) && (r_addr[1:0] == 2'b00);
        grp      = {r_addr[9:4], 4'b0000};
        prt      = r_addr[3:2];
        val      = r_wdata[15:0];
        port_grp = (grp <= gpio_kp_pkg::GRP_EDGE) || (grp == gpio_kp_pkg::GRP_MASK);
        port_ok  = int'(prt) < NUM_PORTS;
        reg_hit  = word && port_grp && port_ok && !grp[4];
        soft_rst = is_bus && wr && (r_size == gpio_kp_pkg::ACC_BYTE) &&
                   (r_addr == gpio_kp_pkg::ADDR_RST) && (r_wdata[7:0] == gpio_kp_pkg::RST_BYTE);
        pin_ok   = (r_cmd == gpio_kp_pkg::CMD_PIN) && (int'(r_port) < NUM_PORTS);
        key_ok   = (r_cmd == gpio_kp_pkg::CMD_KEY) && (int'(r_row) < KEYPAD_SIZE) &&
                   (int'(r_col) < KEYPAD_SIZE);

        do_dir   = 1'b0;
        do_set   = 1'b0;
        do_clr   = 1'b0;
        do_fall  = 1'b0;
        do_rise  = 1'b0;
        do_edge  = 1'b0;
        do_mask  = 1'b0;
        rd_state = 1'b0;
        rd_id    = 1'b0;
        n_ok     = 1'b0;

        if (reg_hit) begin
            case (grp)
                gpio_kp_pkg::GRP_STATE: begin
                    n_ok     = !wr;
                    rd_state = 1'b1;
                end
                gpio_kp_pkg::GRP_DIR: begin
                    n_ok   = 1'b1;
                    do_dir = wr;
                end
                gpio_kp_pkg::GRP_SET: begin
                    n_ok   = wr;
                    do_set = wr;
                end
                gpio_kp_pkg::GRP_CLR: begin
                    n_ok   = wr;
                    do_clr = wr;
                end
                gpio_kp_pkg::GRP_FALL: begin
                    n_ok    = 1'b1;
                    do_fall = wr;
                end
                gpio_kp_pkg::GRP_RISE: begin
                    n_ok    = 1'b1;
                    do_rise = wr;
                end
                gpio_kp_pkg::GRP_EDGE: begin
                    n_ok    = 1'b1;
                    do_edge = wr;
                end
                gpio_kp_pkg::GRP_MASK: begin
                    n_ok    = 1'b1;
                    do_mask = wr;
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end else if (word && !port_grp) begin
            if (r_addr == gpio_kp_pkg::ADDR_ID) begin
                n_ok  = !wr;
                rd_id = 1'b1;
            end else if (r_addr inside {gpio_kp_pkg::ADDR_RSV0, gpio_kp_pkg::ADDR_RSV1,
                                        gpio_kp_pkg::ADDR_RSV2, gpio_kp_pkg::ADDR_RSV3,
                                        gpio_kp_pkg::ADDR_RSV4, gpio_kp_pkg::ADDR_RSV5,
                                        gpio_kp_pkg::ADDR_RSV6, gpio_kp_pkg::ADDR_RSV7,
                                        gpio_kp_pkg::ADDR_RSV8, gpio_kp_pkg::ADDR_RST}) begin
                n_ok = 1'b1;
            end
        end else if (soft_rst || pin_ok || key_ok) begin
            n_ok = 1'b1;
        end

        rd = rd_id ? gpio_kp_pkg::ID_WORD : '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            logic sel;
            sel = (prt == 2'(i));

            a_out[i]  = r_out[i];
            a_ext[i]  = r_ext[i];
            a_dir[i]  = r_dir[i];
            a_rise[i] = r_rise[i];
            a_fall[i] = r_fall[i];
            a_edge[i] = r_edge[i];
            a_mask[i] = r_mask[i];

            if (sel && reg_hit) begin
                if (rd_state) begin
                    rd = r_pst[i];
                end else begin
                    case (grp)
                        gpio_kp_pkg::GRP_DIR:  rd = r_dir[i];
                        gpio_kp_pkg::GRP_FALL: rd = r_fall[i];
                        gpio_kp_pkg::GRP_RISE: rd = r_rise[i];
                        gpio_kp_pkg::GRP_EDGE: rd = r_edge[i];
                        gpio_kp_pkg::GRP_MASK: rd = r_mask[i];
                        default:               rd = '0;
                    endcase
                end
                if (do_dir)  a_dir[i]  = val;
                if (do_set)  a_out[i]  = r_out[i] | val;
                if (do_clr)  a_out[i]  = r_out[i] & ~val;
                if (do_fall) a_fall[i] = val;
                if (do_rise) a_rise[i] = val;
                if (do_edge) a_edge[i] = r_edge[i] & ~val;
                if (do_mask) a_mask[i] = val;
            end

            if (soft_rst) begin
                a_out[i]  = '0;
                a_dir[i]  = '0;
                a_rise[i] = '0;
                a_fall[i] = '0;
                a_edge[i] = '0;
                a_mask[i] = '0;
            end

            if (pin_ok && (r_port == 2'(i))) begin
                a_ext[i][r_pin] = r_level;
            end
        end

        // key matrix tracking
        key_chg = 1'b0;
        for (int r = 0; r < KEYPAD_SIZE; r++) begin
            n_key[r] = r_key[r];
            for (int c = 0; c < KEYPAD_SIZE; c++) begin
                if (key_ok && (r_row == 3'(r)) && (r_col == 3'(c))) begin
                    key_chg     = r_key[r][c] ^ r_pressed;
                    n_key[r][c] = r_pressed;
                end
            end
        end

        // columns are resolved again after any direction, set or clear write and any change of key state
        matrix_run = do_dir || do_set || do_clr || key_chg;

        n_rdata = (n_ok && !wr) ? rd : '0;
    end

    // column read back of the key matrix, from the row drive after this access
    generate
        if (NUM_PORTS > gpio_kp_pkg::KEY_PORT) begin : g_matrix
            always_comb begin
                for (int c = 0; c < KEYPAD_SIZE; c++) begin
                    logic drv_hi;
                    logic drv_lo;
                    drv_hi = 1'b0;
                    drv_lo = 1'b0;
                    for (int r = 0; r < KEYPAD_SIZE; r++) begin
                        if (a_dir[gpio_kp_pkg::KEY_PORT][r] && n_key[r][c]) begin
                            if (a_out[gpio_kp_pkg::KEY_PORT][r]) drv_hi = 1'b1;
                            else                                 drv_lo = 1'b1;
                        end
                    end
                    // low only when pulled low with no row fighting it
                    w_col_hi[c] = !(drv_lo && !drv_hi);
                end
            end
        end else begin : g_no_matrix
            // keys are tracked but drive no port
            assign w_col_hi = '1;
        end
    endgenerate

    // matrix columns into the key port, then pin state and edge detect of every port
    always_comb begin
        logic any_irq;
        any_irq = 1'b0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            gpio_kp_pkg::t_port_upd upd;
            n_ext[i] = a_ext[i];
            if ((i == gpio_kp_pkg::KEY_PORT) && matrix_run) begin
                for (int c = 0; c < KEYPAD_SIZE; c++) begin
                    n_ext[i][gpio_kp_pkg::KEY_COL_BASE + c] = w_col_hi[c];
                end
            end
            // a port whose pin sources did not move sees no change and latches nothing
            upd = gpio_kp_pkg::port_update(r_pst[i], a_out[i], a_dir[i], n_ext[i],
                                           a_fall[i], a_rise[i], a_edge[i]);
            n_pst[i]  = upd.pin;
            n_edge[i] = upd.edges;
            any_irq   = any_irq || ((n_edge[i] & a_mask[i]) != '0);
        end
        n_irq_n = !(r_irq_en && any_irq);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd     <= gpio_kp_pkg::t_cmd'(i_cmd);
            r_addr    <= i_addr;
            r_size    <= i_access_bytes;
            r_wdata   <= i_wdata;
            r_port    <= i_port_sel;
            r_pin     <= i_pin;
            r_level   <= i_level;
            r_row     <= i_key_row;
            r_col     <= i_key_col;
            r_pressed <= i_pressed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rdata <= n_rdata;
            r_ok    <= n_ok;
            r_irq_n <= n_irq_n;
        end
    end

    // irq line enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_irq_en <= i_cfg_wdata;
        end
    end

    // port and key state, committed as the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_out[i]  <= '0;
                r_ext[i]  <= '0;
                r_dir[i]  <= '0;
                r_rise[i] <= '0;
                r_fall[i] <= '0;
                r_edge[i] <= '0;
                r_mask[i] <= '0;
                r_pst[i]  <= '0;
            end
            for (int r = 0; r < KEYPAD_SIZE; r++) begin
                r_key[r] <= '0;
            end
        end else if (advance) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_out[i]  <= a_out[i];
                r_ext[i]  <= n_ext[i];
                r_dir[i]  <= a_dir[i];
                r_rise[i] <= a_rise[i];
                r_fall[i] <= a_fall[i];
                r_edge[i] <= n_edge[i];
                r_mask[i] <= a_mask[i];
                r_pst[i]  <= n_pst[i];
            end
            for (int r = 0; r < KEYPAD_SIZE; r++) begin
                r_key[r] <= n_key[r];
            end
        end
    end

`ifndef NO_ASSERTIONS
    // a failed or write access never returns data
    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> r_rdata == '0)
        else $error("read data on a failed access");

    // with the line disabled the irq output stays released
    a_irq_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_irq_en |-> r_irq_n)
        else $error("irq driven while line disabled");

    // an item leaving the input register always shows up as a result beat
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("item lost between stages");

    // input is held back only by a full and stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without cause");
`endif

endmodule

// ===== sim/gpio_keypad_edge_irq_ctrl_tb.sv =====
// self-checking testbench for the gpio keypad edge irq controller
`timescale 1ns / 1ps

module gpio_keypad_edge_irq_ctrl_tb;

    typedef gpio_kp_pkg::t_word t_word;
    typedef gpio_kp_pkg::t_cmd  t_cmd;

    localparam int NUM_PORTS   = 4;
    localparam int KEYPAD_SIZE = 8;
    // cycles with no beat moving on either channel before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // quiet cycles waited after the last result
    localparam int SETTLE      = 8;
    localparam int RAND_BEATS  = 345;

    typedef struct {
        t_cmd        cmd;
        logic [9:0]  addr;
        logic [2:0]  access_bytes;
        logic [31:0] wdata;
        logic [1:0]  port_sel;
        logic [3:0]  pin;
        logic        level;
        logic [2:0]  key_row;
        logic [2:0]  key_col;
        logic        pressed;
    } t_req;

    typedef struct {
        t_word rdata;
        logic  ok;
        logic  irq_n;
    } t_resp;

    // dut ports, all inputs known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_wdata    = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd          = '0;
    logic [9:0]  i_addr         = '0;
    logic [2:0]  i_access_bytes = '0;
    logic [31:0] i_wdata        = '0;
    logic [1:0]  i_port_sel     = '0;
    logic [3:0]  i_pin          = '0;
    logic        i_level        = 1'b0;
    logic [2:0]  i_key_row      = '0;
    logic [2:0]  i_key_col      = '0;
    logic        i_pressed      = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [15:0] o_rdata;
    logic        o_ok;
    logic        o_irq_n;

    gpio_keypad_edge_irq_ctrl #(
        .NUM_PORTS   (NUM_PORTS),
        .KEYPAD_SIZE (KEYPAD_SIZE)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_addr         (i_addr),
        .i_access_bytes (i_access_bytes),
        .i_wdata        (i_wdata),
        .i_port_sel     (i_port_sel),
        .i_pin          (i_pin),
        .i_level        (i_level),
        .i_key_row      (i_key_row),
        .i_key_col      (i_key_col),
        .i_pressed      (i_pressed),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rdata        (o_rdata),
        .o_ok           (o_ok),
        .o_irq_n        (o_irq_n)
    );

    // beats waiting to be driven and responses waiting to come out
    t_req  req_q[$];
    t_resp resp_q[$];

    int fail_count    = 0;
    int beats_in      = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    logic hold_done   = 1'b0;
    logic in_taken    = 1'b0;

    // shadow copy of the block state
    t_word      gp_latch [4] = '{default: '0};
    t_word      gp_ext   [4] = '{default: '0};
    t_word      gp_dir   [4] = '{default: '0};
    t_word      gp_rise  [4] = '{default: '0};
    t_word      gp_fall  [4] = '{default: '0};
    t_word      gp_edge  [4] = '{default: '0};
    t_word      gp_mask  [4] = '{default: '0};
    t_word      gp_pin   [4] = '{default: '0};
    logic [7:0] keys     [8] = '{default: '0};
    logic       irq_line_en  = 1'b1;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // pin state follows latch on outputs and the outside level on inputs,
    // enabled transitions land in the edge latch
    function automatic void refresh_port(int p);
        t_word prev;
        t_word nxt;
        t_word chg;
        prev = gp_pin[p];
        nxt  = (gp_latch[p] & gp_dir[p]) | (gp_ext[p] & ~gp_dir[p]);
        chg  = prev ^ nxt;
        gp_edge[p] = gp_edge[p] | (chg & prev & gp_fall[p]) | (chg & nxt & gp_rise[p]);
        gp_pin[p]  = nxt;
    endfunction

    // a column reads low only when pulled by a low row and by no high row
    function automatic void resolve_columns();
        logic hi;
        logic lo;
        for (int c = 0; c < KEYPAD_SIZE; c++) begin
            hi = 1'b0;
            lo = 1'b0;
            for (int r = 0; r < KEYPAD_SIZE; r++) begin
                if (gp_dir[gpio_kp_pkg::KEY_PORT][r] && keys[r][c]) begin
                    if (gp_latch[gpio_kp_pkg::KEY_PORT][r]) hi = 1'b1;
                    else lo = 1'b1;
                end
            end
            gp_ext[gpio_kp_pkg::KEY_PORT][gpio_kp_pkg::KEY_COL_BASE + c] = !(lo && !hi);
        end
        refresh_port(gpio_kp_pkg::KEY_PORT);
    endfunction

    // one aligned word access; returns whether it is handled
    function automatic logic word_access(logic [9:0] a, logic wr, t_word val,
                                         output t_word rd);
        int         p;
        logic [9:0] grp;
        rd  = '0;
        p   = int'(a[3:2]);
        grp = a & 10'h3f0;
        if (a[1:0] != 2'b00) return 1'b0;
        if (grp <= gpio_kp_pkg::GRP_EDGE || grp == gpio_kp_pkg::GRP_MASK) begin
            if (p >= NUM_PORTS || grp[4]) return 1'b0;
            case (grp)
                gpio_kp_pkg::GRP_STATE: begin
                    if (wr) return 1'b0;
                    rd = gp_pin[p];
                end
                gpio_kp_pkg::GRP_DIR: begin
                    if (wr) begin
                        gp_dir[p] = val;
                        resolve_columns();
                        refresh_port(p);
                    end else rd = gp_dir[p];
                end
                gpio_kp_pkg::GRP_SET: begin
                    if (!wr) return 1'b0;
                    gp_latch[p] = gp_latch[p] | val;
                    resolve_columns();
                    refresh_port(p);
                end
                gpio_kp_pkg::GRP_CLR: begin
                    if (!wr) return 1'b0;
                    gp_latch[p] = gp_latch[p] & ~val;
                    resolve_columns();
                    refresh_port(p);
                end
                gpio_kp_pkg::GRP_FALL: begin
                    if (wr) gp_fall[p] = val; else rd = gp_fall[p];
                end
                gpio_kp_pkg::GRP_RISE: begin
                    if (wr) gp_rise[p] = val; else rd = gp_rise[p];
                end
                gpio_kp_pkg::GRP_EDGE: begin
                    if (wr) gp_edge[p] = gp_edge[p] & ~val; else rd = gp_edge[p];
                end
                default: begin
                    if (wr) gp_mask[p] = val; else rd = gp_mask[p];
                end
            endcase
            return 1'b1;
        end
        case (a)
            gpio_kp_pkg::ADDR_ID: begin
                if (wr) return 1'b0;
                rd = gpio_kp_pkg::ID_WORD;
                return 1'b1;
            end
            gpio_kp_pkg::ADDR_RSV0, gpio_kp_pkg::ADDR_RSV1, gpio_kp_pkg::ADDR_RSV2,
            gpio_kp_pkg::ADDR_RSV3, gpio_kp_pkg::ADDR_RSV4, gpio_kp_pkg::ADDR_RSV5,
            gpio_kp_pkg::ADDR_RSV6, gpio_kp_pkg::ADDR_RSV7, gpio_kp_pkg::ADDR_RSV8,
            gpio_kp_pkg::ADDR_RST: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // response to one accepted beat, updating the shadow state
    function automatic t_resp gpio_response(t_req rq);
        t_resp rs;
        t_word rd;
        logic  ok;
        logic  act;
        rd  = '0;
        ok  = 1'b0;
        act = 1'b0;
        case (rq.cmd)
            gpio_kp_pkg::CMD_READ, gpio_kp_pkg::CMD_WRITE: begin
                if (rq.access_bytes == gpio_kp_pkg::ACC_WORD) begin
                    ok = word_access(rq.addr, rq.cmd == gpio_kp_pkg::CMD_WRITE,
                                     rq.wdata[15:0], rd);
                    if (!ok || rq.cmd == gpio_kp_pkg::CMD_WRITE) rd = '0;
                end else if (rq.access_bytes == gpio_kp_pkg::ACC_BYTE &&
                             rq.cmd == gpio_kp_pkg::CMD_WRITE &&
                             rq.addr == gpio_kp_pkg::ADDR_RST &&
                             rq.wdata[7:0] == gpio_kp_pkg::RST_BYTE) begin
                    // soft reset keeps outside levels, keys and the line enable
                    for (int p = 0; p < 4; p++) begin
                        gp_latch[p] = '0;
                        gp_dir[p]   = '0;
                        gp_rise[p]  = '0;
                        gp_fall[p]  = '0;
                        gp_edge[p]  = '0;
                        gp_mask[p]  = '0;
                        gp_pin[p]   = gp_ext[p];
                    end
                    ok = 1'b1;
                end
            end
            gpio_kp_pkg::CMD_PIN: begin
                if (int'(rq.port_sel) < NUM_PORTS) begin
                    gp_ext[rq.port_sel][rq.pin] = rq.level;
                    refresh_port(int'(rq.port_sel));
                    ok = 1'b1;
                end
            end
            default: begin
                if (int'(rq.key_row) < KEYPAD_SIZE && int'(rq.key_col) < KEYPAD_SIZE) begin
                    // only a real change of key state rescans the matrix
                    if (keys[rq.key_row][rq.key_col] != rq.pressed) begin
                        keys[rq.key_row][rq.key_col] = rq.pressed;
                        resolve_columns();
                    end
                    ok = 1'b1;
                end
            end
        endcase
        for (int p = 0; p < NUM_PORTS; p++)
            if (|(gp_edge[p] & gp_mask[p])) act = 1'b1;
        rs.rdata = rd;
        rs.ok    = ok;
        rs.irq_n = (irq_line_en && act) ? 1'b0 : 1'b1;
        return rs;
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    function automatic logic [9:0] reg_addr(logic [9:0] grp, int p);
        return grp + 10'(p * 4);
    endfunction

    // every field random, so idle fields still toggle
    function automatic t_req any_beat();
        t_req rq;
        rq.cmd          = t_cmd'(2'($urandom_range(0, 3)));
        rq.addr         = 10'($urandom_range(0, 543));
        rq.access_bytes = 3'($urandom_range(1, 4));
        rq.wdata        = $urandom;
        rq.port_sel     = 2'($urandom_range(0, 3));
        rq.pin          = 4'($urandom_range(0, 15));
        rq.level        = 1'($urandom_range(0, 1));
        rq.key_row      = 3'($urandom_range(0, 7));
        rq.key_col      = 3'($urandom_range(0, 7));
        rq.pressed      = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    function automatic t_req bus_beat(t_cmd c, logic [9:0] a, logic [2:0] sz,
                                      logic [31:0] d);
        t_req rq;
        rq              = any_beat();
        rq.cmd          = c;
        rq.addr         = a;
        rq.access_bytes = sz;
        rq.wdata        = d;
        return rq;
    endfunction

    function automatic t_req pin_beat(int p, int n, logic lv);
        t_req rq;
        rq          = any_beat();
        rq.cmd      = gpio_kp_pkg::CMD_PIN;
        rq.port_sel = 2'(p);
        rq.pin      = 4'(n);
        rq.level    = lv;
        return rq;
    endfunction

    function automatic t_req key_beat(int r, int c, logic pr);
        t_req rq;
        rq         = any_beat();
        rq.cmd     = gpio_kp_pkg::CMD_KEY;
        rq.key_row = 3'(r);
        rq.key_col = 3'(c);
        rq.pressed = pr;
        return rq;
    endfunction

    // mostly mapped registers with real sizes, some soft resets, pin and key traffic
    function automatic t_req random_beat();
        t_req       rq;
        int         sel;
        int         pick;
        logic [9:0] grp;
        rq  = any_beat();
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            rq.cmd = (sel < 24) ? gpio_kp_pkg::CMD_READ : gpio_kp_pkg::CMD_WRITE;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 7))
                    0: grp = gpio_kp_pkg::GRP_STATE;
                    1: grp = gpio_kp_pkg::GRP_DIR;
                    2: grp = gpio_kp_pkg::GRP_SET;
                    3: grp = gpio_kp_pkg::GRP_CLR;
                    4: grp = gpio_kp_pkg::GRP_FALL;
                    5: grp = gpio_kp_pkg::GRP_RISE;
                    6: grp = gpio_kp_pkg::GRP_EDGE;
                    default: grp = gpio_kp_pkg::GRP_MASK;
                endcase
                rq.addr = reg_addr(grp, $urandom_range(0, 3));
            end else if (pick < 85) begin
                case ($urandom_range(0, 10))
                    0: rq.addr = gpio_kp_pkg::ADDR_ID;
                    1: rq.addr = gpio_kp_pkg::ADDR_RSV0;
                    2: rq.addr = gpio_kp_pkg::ADDR_RSV1;
                    3: rq.addr = gpio_kp_pkg::ADDR_RSV2;
                    4: rq.addr = gpio_kp_pkg::ADDR_RSV3;
                    5: rq.addr = gpio_kp_pkg::ADDR_RSV4;
                    6: rq.addr = gpio_kp_pkg::ADDR_RSV5;
                    7: rq.addr = gpio_kp_pkg::ADDR_RSV6;
                    8: rq.addr = gpio_kp_pkg::ADDR_RSV7;
                    9: rq.addr = gpio_kp_pkg::ADDR_RSV8;
                    default: rq.addr = gpio_kp_pkg::ADDR_RST;
                endcase
            end
            rq.access_bytes = ($urandom_range(0, 99) < 88) ? gpio_kp_pkg::ACC_WORD :
                              3'($urandom_range(1, 3));
        end else if (sel < 52) begin
            rq.cmd               = gpio_kp_pkg::CMD_WRITE;
            rq.addr              = gpio_kp_pkg::ADDR_RST;
            rq.access_bytes      = gpio_kp_pkg::ACC_BYTE;
            rq.wdata[7:0]        = gpio_kp_pkg::RST_BYTE;
        end else if (sel < 76) begin
            rq.cmd = gpio_kp_pkg::CMD_PIN;
        end else begin
            rq.cmd = gpio_kp_pkg::CMD_KEY;
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // clock, driver, receiver, monitor, watchdog
    // ------------------------------------------------------------------

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // input side: a new beat only after the last one was taken
    always @(negedge i_clk) begin : drive_in
        t_req nx;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nx              = req_q.pop_front();
                i_in_valid     <= 1'b1;
                i_cmd          <= nx.cmd;
                i_addr         <= nx.addr;
                i_access_bytes <= nx.access_bytes;
                i_wdata        <= nx.wdata;
                i_port_sel     <= nx.port_sel;
                i_pin          <= nx.pin;
                i_level        <= nx.level;
                i_key_row      <= nx.key_row;
                i_key_col      <= nx.key_col;
                i_pressed      <= nx.pressed;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side: random stall plus one long hold-off that backs the pipe up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && beats_in >= 200) begin
            i_out_stall <= 1'b1;
            hold_left   <= 150;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_req  got;
        t_resp want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (resp_q.size() == 0) begin
                    $error("result beat with no response expected");
                    fail_count = fail_count + 1;
                end else begin
                    want = resp_q.pop_front();
                    if (o_rdata !== want.rdata) begin
                        $error("rdata expected %h actual %h", want.rdata, o_rdata);
                        fail_count = fail_count + 1;
                    end
                    if (o_ok !== want.ok) begin
                        $error("ok expected %b actual %b", want.ok, o_ok);
                        fail_count = fail_count + 1;
                    end
                    if (o_irq_n !== want.irq_n) begin
                        $error("irq_n expected %b actual %b", want.irq_n, o_irq_n);
                        fail_count = fail_count + 1;
                    end
                end
            end
            in_taken <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                got.cmd          = t_cmd'(i_cmd);
                got.addr         = i_addr;
                got.access_bytes = i_access_bytes;
                got.wdata        = i_wdata;
                got.port_sel     = i_port_sel;
                got.pin          = i_pin;
                got.level        = i_level;
                got.key_row      = i_key_row;
                got.key_col      = i_key_col;
                got.pressed      = i_pressed;
                resp_q.push_back(gpio_response(got));
                beats_in <= beats_in + 1;
            end
        end
    end

    // hang detection: no beat moving on either side for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    // register write while the block is idle, shadow follows
    task automatic write_irq_enable(logic v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        irq_line_en = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // wait until every beat went in and every response came out
    task automatic drain();
        while (req_q.size() > 0 || i_in_valid || resp_q.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_phase(logic en, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_irq_enable(en);
        for (int k = 0; k < RAND_BEATS; k++)
            req_q.push_back(random_beat());
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part: sender idles lightly, receiver heavily
        send_idle_pct = 14;
        recv_idle_pct = 65;
        write_irq_enable(1'b1);
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_READ, gpio_kp_pkg::ADDR_ID,
                                 gpio_kp_pkg::ACC_WORD, 32'h0));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE, gpio_kp_pkg::ADDR_ID,
                                 gpio_kp_pkg::ACC_WORD, 32'hffffffff));
        // wrong direction on state and set
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE, reg_addr(gpio_kp_pkg::GRP_STATE, 0),
                                 gpio_kp_pkg::ACC_WORD, 32'hffff));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_READ, reg_addr(gpio_kp_pkg::GRP_SET, 3),
                                 gpio_kp_pkg::ACC_WORD, 32'h0));
        // arm every edge of the key port and unmask it
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE,
                                 reg_addr(gpio_kp_pkg::GRP_MASK, gpio_kp_pkg::KEY_PORT),
                                 gpio_kp_pkg::ACC_WORD, 32'hffffffff));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE,
                                 reg_addr(gpio_kp_pkg::GRP_FALL, gpio_kp_pkg::KEY_PORT),
                                 gpio_kp_pkg::ACC_WORD, 32'h0000ffff));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE,
                                 reg_addr(gpio_kp_pkg::GRP_RISE, gpio_kp_pkg::KEY_PORT),
                                 gpio_kp_pkg::ACC_WORD, 32'h0000ffff));
        // rows become low outputs, columns float high
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE,
                                 reg_addr(gpio_kp_pkg::GRP_DIR, gpio_kp_pkg::KEY_PORT),
                                 gpio_kp_pkg::ACC_WORD, 32'h000000ff));
        req_q.push_back(key_beat(0, 0, 1'b1));
        req_q.push_back(key_beat(7, 7, 1'b1));
        // same key again changes nothing
        req_q.push_back(key_beat(7, 7, 1'b1));
        // row 0 driven high, then a high and a low row share column 7
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE,
                                 reg_addr(gpio_kp_pkg::GRP_SET, gpio_kp_pkg::KEY_PORT),
                                 gpio_kp_pkg::ACC_WORD, 32'h1));
        req_q.push_back(key_beat(0, 7, 1'b1));
        req_q.push_back(key_beat(7, 7, 1'b0));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_READ,
                                 reg_addr(gpio_kp_pkg::GRP_EDGE, gpio_kp_pkg::KEY_PORT),
                                 gpio_kp_pkg::ACC_WORD, 32'h0));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE,
                                 reg_addr(gpio_kp_pkg::GRP_EDGE, gpio_kp_pkg::KEY_PORT),
                                 gpio_kp_pkg::ACC_WORD, 32'hffffffff));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_READ,
                                 reg_addr(gpio_kp_pkg::GRP_STATE, gpio_kp_pkg::KEY_PORT),
                                 gpio_kp_pkg::ACC_WORD, 32'h0));
        req_q.push_back(pin_beat(3, 15, 1'b1));
        req_q.push_back(pin_beat(0, 0, 1'b0));
        // outside level forced onto a column pin
        req_q.push_back(pin_beat(gpio_kp_pkg::KEY_PORT, gpio_kp_pkg::KEY_COL_BASE, 1'b0));
        // unaligned, unmapped hole, reserved words, odd sizes
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_READ, gpio_kp_pkg::ADDR_ID + 10'd2,
                                 gpio_kp_pkg::ACC_WORD, 32'h0));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_READ, 10'h010,
                                 gpio_kp_pkg::ACC_WORD, 32'h0));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_READ, gpio_kp_pkg::ADDR_RSV0,
                                 gpio_kp_pkg::ACC_WORD, 32'h0));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE, gpio_kp_pkg::ADDR_RSV8,
                                 gpio_kp_pkg::ACC_WORD, 32'hffffffff));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_READ, gpio_kp_pkg::ADDR_ID, 3'd2, 32'h0));
        // byte write at the reset word: wrong byte, then the real soft reset
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE, gpio_kp_pkg::ADDR_RST,
                                 gpio_kp_pkg::ACC_BYTE, 32'h00000000));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE, gpio_kp_pkg::ADDR_RST,
                                 gpio_kp_pkg::ACC_BYTE, 32'hffffffff));
        req_q.push_back(bus_beat(gpio_kp_pkg::CMD_WRITE, 10'd543, 3'd3, 32'h0));
        drain();

        // random part across line enable settings and idle patterns
        random_phase(1'b0, 14, 65);
        random_phase(1'b1, 65, 14);
        random_phase(1'b0, 0, 0);
        random_phase(1'b1, 0, 0);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
